### rtl/core/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and constants of the replay block deframer
// Holds the result word carried from the parser to the output stage.
// ----------------------------------------------------------------------------
package rbd_pkg;

    // result kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_CONTENT = 1'b1;

    // decoupling queue between parser and output stage
    localparam int RBD_QDEPTH = 2;
    localparam int RBD_QAW    = $clog2(RBD_QDEPTH);
    localparam int RBD_QCW    = $clog2(RBD_QDEPTH + 1);

    // one result word
    typedef struct packed {
        logic        result_kind;
        logic [3:0]  marker_bits;
        logic [31:0] timestamp_bits;
        logic [31:0] content_length;
        logic [7:0]  block_type;
        logic [31:0] block_param;
        logic [7:0]  content_byte;
        logic        last_of_block;
    } t_rbd_item;

endpackage

### rtl/core/rbd_fadd.sv
// ----------------------------------------------------------------------------
// rbd_fadd: single-precision add of a float and an unsigned byte
// Two stages: align and add, then normalize and round to nearest even.
// ----------------------------------------------------------------------------
module rbd_fadd
    import rbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [31:0] i_prev_bits,
    input  logic [7:0]  i_delta,
    output logic [31:0] o_sum
);

    // operand registers
    logic [31:0] r_a;
    logic [7:0]  r_d;

    // align/add stage registers
    logic [31:0] r_s_a;
    logic        r_s_spec;
    logic        r_s_sign;
    logic [7:0]  r_s_exp;
    logic [27:0] r_s_mag;

    logic [31:0] n_s_a;
    logic        n_s_spec;
    logic        n_s_sign;
    logic [7:0]  n_s_exp;
    logic [27:0] n_s_mag;

    // shift right into a 27-bit word with guard, round and sticky
    function automatic logic [26:0] shr_sticky(input logic [23:0] m, input logic [7:0] sh);
        logic [26:0] x;
        logic [26:0] lost;
        x = {m, 3'b000};
        lost = '0;
        if (sh >= 8'd27) begin
            shr_sticky = {26'd0, |m};
        end else begin
            lost = x & ~({27{1'b1}} << sh[4:0]);
            shr_sticky = (x >> sh[4:0]) | {26'd0, |lost};
        end
    endfunction

    // load operands when a delta byte arrives
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= i_prev_bits;
            r_d <= i_delta;
        end
    end

    // align and add
    always_comb begin
        logic [7:0]  a_exp;
        logic [7:0]  a_ee;
        logic [23:0] a_m;
        logic [2:0]  k;
        logic [23:0] d_m;
        logic [7:0]  d_e;
        logic [26:0] av;
        logic [26:0] dv;
        a_exp = r_a[30:23];
        a_ee  = (a_exp == 8'd0) ? 8'd1 : a_exp;
        a_m   = {a_exp != 8'd0, r_a[22:0]};
        k = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (r_d[i]) begin
                k = 3'(7 - i);
            end
        end
        if (r_d == 8'd0) begin
            d_m = '0;
            d_e = 8'd1;
        end else begin
            d_m = {r_d, 16'd0} << k;
            d_e = 8'd134 - {5'd0, k};
        end
        if (a_ee >= d_e) begin
            n_s_exp = a_ee;
            av = {a_m, 3'b000};
            dv = shr_sticky(d_m, a_ee - d_e);
        end else begin
            n_s_exp = d_e;
            dv = {d_m, 3'b000};
            av = shr_sticky(a_m, d_e - a_ee);
        end
        if (!r_a[31]) begin
            n_s_mag  = {1'b0, av} + {1'b0, dv};
            n_s_sign = 1'b0;
        end else if (dv >= av) begin
            n_s_mag  = {1'b0, dv - av};
            n_s_sign = 1'b0;
        end else begin
            n_s_mag  = {1'b0, av - dv};
            n_s_sign = 1'b1;
        end
        n_s_spec = (a_exp == 8'hFF);
        n_s_a    = r_a;
    end

    always_ff @(posedge i_clk) begin
        r_s_a    <= n_s_a;
        r_s_spec <= n_s_spec;
        r_s_sign <= n_s_sign;
        r_s_exp  <= n_s_exp;
        r_s_mag  <= n_s_mag;
    end

    // normalize and round
    always_comb begin
        logic [26:0] nm;
        logic [8:0]  e1;
        logic [8:0]  e2;
        logic [4:0]  lz;
        logic [8:0]  sh;
        logic        up;
        logic [24:0] mant;
        logic [22:0] frac;
        lz = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (r_s_mag[i]) begin
                lz = 5'(26 - i);
            end
        end
        sh = '0;
        if (r_s_mag[27]) begin
            nm = {r_s_mag[27:2], r_s_mag[1] | r_s_mag[0]};
            e1 = {1'b0, r_s_exp} + 9'd1;
        end else begin
            sh = ({4'd0, lz} < ({1'b0, r_s_exp} - 9'd1)) ? {4'd0, lz}
                                                          : ({1'b0, r_s_exp} - 9'd1);
            nm = r_s_mag[26:0] << sh[4:0];
            e1 = {1'b0, r_s_exp} - sh;
        end
        up   = nm[2] & (nm[1] | nm[0] | nm[3]);
        mant = {1'b0, nm[26:3]} + {24'd0, up};
        if (mant[24]) begin
            e2   = e1 + 9'd1;
            frac = mant[23:1];
        end else begin
            e2   = mant[23] ? e1 : 9'd0;
            frac = mant[22:0];
        end
        if (r_s_spec) begin
            o_sum = r_s_a | {9'd0, r_s_a[22:0] != 23'd0, 22'd0};
        end else if (e2 >= 9'd255) begin
            o_sum = {r_s_sign, 8'hFF, 23'd0};
        end else begin
            o_sum = {r_s_sign, e2[7:0], frac};
        end
    end

endmodule

### rtl/core/rbd_front.sv
// ----------------------------------------------------------------------------
// rbd_front: block parser
// Walks the marker and header fields and emits one word per result.
// ----------------------------------------------------------------------------
module rbd_front
    import rbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_full,
    output logic        o_stall,
    output logic        o_push,
    output t_rbd_item   o_item
);

    typedef enum logic [2:0] {
        PH_MARKER,
        PH_TIME,
        PH_LENGTH,
        PH_TYPE,
        PH_PARAM,
        PH_CONTENT
    } t_phase;

    t_phase      r_phase;
    logic [1:0]  r_idx;
    logic [3:0]  r_flags;
    logic [31:0] r_time_acc;
    logic [31:0] r_prev;
    logic [31:0] r_len;
    logic [7:0]  r_type;
    logic [31:0] r_param;
    logic [31:0] r_remain;

    logic        take;
    logic [31:0] shifted;
    logic [31:0] param_new;
    logic [31:0] fadd_sum;
    logic [31:0] hdr_time;
    logic        fadd_load;
    logic        param_done;

    assign o_stall    = i_full;
    assign take       = i_valid && !i_full;
    assign shifted    = {24'd0, i_data_byte} << {r_idx, 3'b000};
    assign param_new  = r_param | shifted;
    assign hdr_time   = r_flags[0] ? fadd_sum : r_time_acc;
    assign fadd_load  = take && (r_phase == PH_TIME) && r_flags[0];
    assign param_done = r_flags[2] || (r_idx == 2'd3);

    rbd_fadd u_fadd (
        .i_clk       (i_clk),
        .i_load      (fadd_load),
        .i_prev_bits (r_prev),
        .i_delta     (i_data_byte),
        .o_sum       (fadd_sum)
    );

    // build the result word
    always_comb begin
        o_push = 1'b0;
        o_item = '0;
        if (r_phase == PH_PARAM) begin
            o_push                = take && param_done;
            o_item.result_kind    = KIND_HEADER;
            o_item.marker_bits    = r_flags;
            o_item.timestamp_bits = hdr_time;
            o_item.content_length = r_len;
            o_item.block_type     = r_type;
            o_item.block_param    = param_new;
            o_item.content_byte   = 8'd0;
            o_item.last_of_block  = (r_len == 32'd0);
        end else begin
            o_push                = take && (r_phase == PH_CONTENT);
            o_item.result_kind    = KIND_CONTENT;
            o_item.marker_bits    = r_flags;
            o_item.timestamp_bits = r_prev;
            o_item.content_length = r_len;
            o_item.block_type     = r_type;
            o_item.block_param    = r_param;
            o_item.content_byte   = i_data_byte;
            o_item.last_of_block  = (r_remain == 32'd1);
        end
    end

    // advance the parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_MARKER;
            r_idx      <= '0;
            r_flags    <= '0;
            r_time_acc <= '0;
            r_prev     <= '0;
            r_len      <= '0;
            r_type     <= '0;
            r_param    <= '0;
            r_remain   <= '0;
        end else if (take) begin
            unique case (r_phase)
                PH_MARKER: begin
                    r_flags    <= i_data_byte[3:0];
                    r_time_acc <= '0;
                    r_len      <= '0;
                    r_type     <= '0;
                    r_param    <= '0;
                    r_idx      <= '0;
                    r_phase    <= PH_TIME;
                end
                PH_TIME: begin
                    if (r_flags[0]) begin
                        r_idx   <= '0;
                        r_phase <= PH_LENGTH;
                    end else begin
                        r_time_acc <= r_time_acc | shifted;
                        r_idx      <= r_idx + 2'd1;
                        if (r_idx == 2'd3) begin
                            r_phase <= PH_LENGTH;
                        end
                    end
                end
                PH_LENGTH: begin
                    r_len <= r_len | shifted;
                    if (r_flags[3] || r_idx == 2'd3) begin
                        r_idx   <= '0;
                        r_phase <= r_flags[1] ? PH_TYPE : PH_PARAM;
                    end else begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                PH_TYPE: begin
                    r_type  <= i_data_byte;
                    r_phase <= PH_PARAM;
                end
                PH_PARAM: begin
                    r_param <= param_new;
                    if (param_done) begin
                        r_idx    <= '0;
                        r_prev   <= hdr_time;
                        r_remain <= r_len;
                        r_phase  <= (r_len == 32'd0) ? PH_MARKER : PH_CONTENT;
                    end else begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                PH_CONTENT: begin
                    r_remain <= r_remain - 32'd1;
                    if (r_remain == 32'd1) begin
                        r_phase <= PH_MARKER;
                    end
                end
                default: begin
                    r_phase <= PH_MARKER;
                    r_idx   <= '0;
                end
            endcase
        end
    end

endmodule

### rtl/core/rbd_queue.sv
// ----------------------------------------------------------------------------
// rbd_queue: short word queue between parser and output stage
// Lets either side stall without holding up the other.
// ----------------------------------------------------------------------------
module rbd_queue
    import rbd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_rbd_item i_item,
    input  logic      i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_rbd_item o_item
);

    t_rbd_item            r_mem [RBD_QDEPTH];
    logic [RBD_QAW-1:0]   r_wr;
    logic [RBD_QAW-1:0]   r_rd;
    logic [RBD_QCW-1:0]   r_count;

    assign o_full  = (r_count == RBD_QCW'(RBD_QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    // store words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == RBD_QAW'(RBD_QDEPTH - 1)) ? '0 : r_wr + RBD_QAW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == RBD_QAW'(RBD_QDEPTH - 1)) ? '0 : r_rd + RBD_QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + RBD_QCW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - RBD_QCW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RBD_QCW'(RBD_QDEPTH))
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + RBD_QCW'(1)))
        else $error("queue count did not advance");

endmodule

### rtl/core/rbd_back.sv
// ----------------------------------------------------------------------------
// rbd_back: output stage
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module rbd_back
    import rbd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_rbd_item i_q_item,
    input  logic      i_stall,
    output logic      o_pop,
    output logic      o_valid,
    output t_rbd_item o_item
);

    logic      r_valid;
    t_rbd_item r_item;

    assign o_pop   = i_q_valid && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // refill the output register when it empties or is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_q_item;
        end
    end

endmodule

### rtl/core/replay_block_deframer_core.sv
// ----------------------------------------------------------------------------
// replay_block_deframer_core: replay block stream deframer
// Parses marker, time, length, type and param fields and passes content.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock while the queue is not full. A header word
// goes through the queue and the output register once the last param byte is
// taken, then one word per content byte at one per clock unless stalled.
// A relative time goes through a two-stage single-precision adder, which is
// loaded by the delta byte and finishes before the earliest param byte; a
// two-word queue and an output register decouple the parser from the output.
module replay_block_deframer_core
    import rbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [3:0]  o_marker_bits,
    output logic [31:0] o_timestamp_bits,
    output logic [31:0] o_content_length,
    output logic [7:0]  o_block_type,
    output logic [31:0] o_block_param,
    output logic [7:0]  o_content_byte,
    output logic        o_last_of_block
);

    logic      push;
    logic      full;
    logic      q_valid;
    logic      pop;
    t_rbd_item push_item;
    t_rbd_item q_item;
    t_rbd_item out_item;

    rbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_full      (full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_item      (push_item)
    );

    rbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    rbd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .i_stall   (i_stall),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .o_item    (out_item)
    );

    // unpack the result word
    assign o_result_kind    = out_item.result_kind;
    assign o_marker_bits    = out_item.marker_bits;
    assign o_timestamp_bits = out_item.timestamp_bits;
    assign o_content_length = out_item.content_length;
    assign o_block_type     = out_item.block_type;
    assign o_block_param    = out_item.block_param;
    assign o_content_byte   = out_item.content_byte;
    assign o_last_of_block  = out_item.last_of_block;

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: replay block deframer core testbench
// Feeds framed replay blocks through the core byte by byte, tracks every
// accepted byte in a behavioral deframer and checks each header and content
// word against it, under random source gaps, sink stalls and one long sink
// hold-off that backs the core up.
// ----------------------------------------------------------------------------
module tb;
    import rbd_pkg::*;

    typedef enum logic [2:0] {
        PH_MARKER, PH_TIME, PH_LENGTH, PH_TYPE, PH_PARAM, PH_CONTENT
    } t_parse_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_result_kind;
    logic [3:0]  o_marker_bits;
    logic [31:0] o_timestamp_bits;
    logic [31:0] o_content_length;
    logic [7:0]  o_block_type;
    logic [31:0] o_block_param;
    logic [7:0]  o_content_byte;
    logic        o_last_of_block;

    replay_block_deframer_core dut (.*);

    // stream and bookkeeping
    logic [7:0]  stream_bytes[$];
    t_rbd_item   expected_words[$];
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    bit          pressure_go = 1'b0;
    int          hold_left = 0;
    bit          in_fire = 1'b0;
    int          error_count = 0;
    int          bytes_sent = 0;
    int          headers_seen = 0;
    int          contents_seen = 0;
    int          blocks_built = 0;

    // behavioral deframer state
    t_parse_phase ph = PH_MARKER;
    logic [1:0]  fidx = '0;
    logic [3:0]  flags = '0;
    logic [31:0] time_acc = '0;
    logic [31:0] time_prev = '0;
    logic [31:0] len_reg = '0;
    logic [7:0]  type_reg = '0;
    logic [31:0] param_reg = '0;
    logic [31:0] remain = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // single-precision add, round to nearest even
    function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
        logic        sx, sy;
        int          ex, ey, ex_tmp, diff;
        logic [23:0] mx, my, m_tmp;
        logic [63:0] wx, wy, s;
        logic [31:0] rem;
        logic [24:0] mant;
        logic        rsign;
        sx = a[31]; sy = b[31];
        ex = (a[30:23] == 0) ? 1 : a[30:23];
        ey = (b[30:23] == 0) ? 1 : b[30:23];
        mx = (a[30:23] == 0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
        my = (b[30:23] == 0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
        if (a[30:23] == 8'hFF && a[22:0] != 0) return a | 32'h0040_0000;
        if (a[30:23] == 8'hFF) return a;
        if (b[30:0] > a[30:0]) begin
            rsign = sx; sx = sy; sy = rsign;
            ex_tmp = ex; ex = ey; ey = ex_tmp;
            m_tmp = mx; mx = my; my = m_tmp;
        end
        diff = ex - ey;
        wx = {8'd0, mx, 32'd0};
        wy = {8'd0, my, 32'd0};
        if (diff >= 60) wy = (my != 0) ? 64'd1 : 64'd0;
        else if (diff > 0) wy = (wy >> diff) | ((wy & ((64'd1 << diff) - 1)) != 0);
        s = (sx == sy) ? wx + wy : wx - wy;
        if (s == 0) return 32'd0;
        rsign = sx;
        if (s[56]) begin
            s = (s >> 1) | s[0];
            ex++;
        end
        while (!s[55] && ex > 1) begin
            s = s << 1;
            ex--;
        end
        mant = {1'b0, s[55:32]};
        rem = s[31:0];
        if (rem > 32'h8000_0000 || (rem == 32'h8000_0000 && mant[0])) mant++;
        if (mant[24]) begin
            mant = mant >> 1;
            ex++;
        end
        if (ex >= 255) return {rsign, 8'hFF, 23'd0};
        return {rsign, (mant[23] ? ex[7:0] : 8'd0), mant[22:0]};
    endfunction

    function automatic logic [31:0] byte_to_sp(input logic [7:0] d);
        int p;
        if (d == 0) return 32'd0;
        p = 7;
        while (!d[p]) p--;
        return {1'b0, 8'(127 + p), 23'({24'd0, d} << (23 - p))};
    endfunction

    // advance the deframer by one accepted byte
    task automatic deframe_byte(input logic [7:0] b);
        t_rbd_item w;
        logic      emit;
        logic [31:0] sh;
        emit = 1'b0;
        sh = {24'd0, b} << (8 * fidx);
        w = '0;
        case (ph)
            PH_MARKER: begin
                flags = b[3:0];
                time_acc = '0; len_reg = '0; type_reg = '0; param_reg = '0;
                fidx = '0;
                ph = PH_TIME;
            end
            PH_TIME: begin
                if (flags[0]) begin
                    time_acc = sp_add(time_prev, byte_to_sp(b));
                    fidx = '0;
                    ph = PH_LENGTH;
                end else begin
                    time_acc |= sh;
                    if (fidx == 2'd3) ph = PH_LENGTH;
                    fidx++;
                end
            end
            PH_LENGTH: begin
                len_reg |= sh;
                if (flags[3] || fidx == 2'd3) begin
                    fidx = '0;
                    ph = flags[1] ? PH_TYPE : PH_PARAM;
                end else fidx++;
            end
            PH_TYPE: begin
                type_reg = b;
                ph = PH_PARAM;
            end
            PH_PARAM: begin
                param_reg |= sh;
                if (flags[2] || fidx == 2'd3) begin
                    fidx = '0;
                    time_prev = time_acc;
                    remain = len_reg;
                    emit = 1'b1;
                    w.result_kind = KIND_HEADER;
                    w.last_of_block = (len_reg == 0);
                    ph = (len_reg == 0) ? PH_MARKER : PH_CONTENT;
                end else fidx++;
            end
            default: begin
                remain--;
                emit = 1'b1;
                w.result_kind = KIND_CONTENT;
                w.content_byte = b;
                w.last_of_block = (remain == 0);
                if (remain == 0) ph = PH_MARKER;
            end
        endcase
        if (emit) begin
            w.marker_bits = flags;
            w.timestamp_bits = time_acc;
            w.content_length = len_reg;
            w.block_type = type_reg;
            w.block_param = param_reg;
            expected_words.push_back(w);
        end
    endtask

    // queue the bytes of one block
    task automatic push_block(input logic [7:0] marker, input logic [31:0] tval,
                              input logic [31:0] len, input logic [7:0] typ,
                              input logic [31:0] param);
        stream_bytes.push_back(marker);
        if (marker[0]) stream_bytes.push_back(tval[7:0]);
        else for (int i = 0; i < 4; i++) stream_bytes.push_back(tval[8*i +: 8]);
        if (marker[3]) stream_bytes.push_back(len[7:0]);
        else for (int i = 0; i < 4; i++) stream_bytes.push_back(len[8*i +: 8]);
        if (marker[1]) stream_bytes.push_back(typ);
        if (marker[2]) stream_bytes.push_back(param[7:0]);
        else for (int i = 0; i < 4; i++) stream_bytes.push_back(param[8*i +: 8]);
        for (int i = 0; i < len; i++) stream_bytes.push_back(8'($urandom));
        blocks_built++;
    endtask

    task automatic push_random_block();
        logic [7:0]  marker;
        logic [31:0] tval, len;
        marker = 8'($urandom);
        case ($urandom_range(0, 3))
            0: tval = $urandom;
            1: tval = {1'b0, 8'($urandom_range(100, 160)), 23'($urandom)};
            2: tval = {1'b1, 8'($urandom_range(120, 150)), 23'($urandom)};
            default: tval = 32'($urandom_range(0, 255));
        endcase
        len = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(10, 30))
                                          : 32'($urandom_range(0, 6));
        push_block(marker, tval, len, 8'($urandom), $urandom);
    endtask

    // sample handshakes and check result words
    always @(posedge i_clk) begin
        in_fire <= i_valid && !o_stall && i_rst_n;
        if (i_rst_n && i_valid && !o_stall) deframe_byte(i_data_byte);
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word kind=%0d", o_result_kind);
                error_count++;
            end else begin
                t_rbd_item e;
                e = expected_words.pop_front();
                if (o_result_kind == KIND_HEADER) headers_seen++;
                else contents_seen++;
                if (o_result_kind !== e.result_kind) begin
                    $error("result_kind exp %0h got %0h", e.result_kind, o_result_kind);
                    error_count++;
                end
                if (o_marker_bits !== e.marker_bits) begin
                    $error("marker_bits exp %0h got %0h", e.marker_bits, o_marker_bits);
                    error_count++;
                end
                if (o_timestamp_bits !== e.timestamp_bits) begin
                    $error("timestamp_bits exp %0h got %0h", e.timestamp_bits,
                           o_timestamp_bits);
                    error_count++;
                end
                if (o_content_length !== e.content_length) begin
                    $error("content_length exp %0h got %0h", e.content_length,
                           o_content_length);
                    error_count++;
                end
                if (o_block_type !== e.block_type) begin
                    $error("block_type exp %0h got %0h", e.block_type, o_block_type);
                    error_count++;
                end
                if (o_block_param !== e.block_param) begin
                    $error("block_param exp %0h got %0h", e.block_param, o_block_param);
                    error_count++;
                end
                if (o_content_byte !== e.content_byte) begin
                    $error("content_byte exp %0h got %0h", e.content_byte, o_content_byte);
                    error_count++;
                end
                if (o_last_of_block !== e.last_of_block) begin
                    $error("last_of_block exp %0h got %0h", e.last_of_block,
                           o_last_of_block);
                    error_count++;
                end
            end
        end
    end

    // source: hold a stalled word, else offer the next one or idle
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !in_fire)) begin
            if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                i_valid <= 1'b1;
                i_data_byte <= stream_bytes.pop_front();
                bytes_sent++;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // sink: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (pressure_go && hold_left == 0) begin
            hold_left <= 300;
            pressure_go <= 1'b0;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < snk_stall_pct);
        end
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: assorted marker layouts, time extremes, zero length, deltas
        push_block(8'h00, 32'h0000_0000, 32'd0, 8'h00, 32'h0000_0000);
        push_block(8'hF1, 32'h0000_00FF, 32'd1, 8'hFF, 32'hFFFF_FFFF);
        push_block(8'h0B, 32'h0000_0000, 32'd2, 8'h5A, 32'h0000_0080);
        push_block(8'h0E, 32'h7F7F_FFFF, 32'd0, 8'hA5, 32'h0000_00FF);
        push_block(8'h01, 32'h0000_00FF, 32'd0, 8'h00, 32'h8000_0001);
        push_block(8'h08, 32'h7F80_0000, 32'd1, 8'h00, 32'h1234_5678);
        push_block(8'h0F, 32'h0000_0001, 32'd0, 8'h3C, 32'h0000_0001);
        push_block(8'h04, 32'hFFFF_FFFF, 32'd0, 8'h00, 32'h0000_0000);
        push_block(8'h0D, 32'h0000_0010, 32'd3, 8'h00, 32'h0000_0042);

        // four phases of random blocks with varied idling; long hold-off in the first
        for (int p = 0; p < 4; p++) begin
            src_idle_pct = (p == 1 || p == 3) ? 65 : 0;
            snk_stall_pct = (p == 2) ? 65 : (p == 3) ? 33 : 0;
            if (p == 3) src_idle_pct = 33;
            if (p == 0) pressure_go = 1'b1;
            while (stream_bytes.size() < 112) push_random_block();
            wait (stream_bytes.size() == 0);
        end
        src_idle_pct = 0;
        snk_stall_pct = 0;
        wait (stream_bytes.size() == 0 && !i_valid);
        wait (expected_words.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("tb: %0d bytes in %0d blocks, %0d headers and %0d content words checked",
                 bytes_sent, blocks_built, headers_seen, contents_seen);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
